// ===== design/cnr_pkg.sv =====
// Shared types and constants of the circle nonpenetration resolver.
`timescale 1ns / 1ps
package cnr_pkg;
    localparam int ENTRIES = 64;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int D2_W = 51;
    localparam int ROOT_W = 26;
    localparam int SQ_STEPS = 26;
    localparam int DIV_STEPS = 26;
    localparam int NUM_W = 51;
    localparam int CNT_MAX = 127;

    typedef struct packed {
        logic              elig;
        logic [23:0]       r;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } circle_t;

    localparam int CIRCLE_W = $bits(circle_t);
endpackage

// ===== design/cnr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module cnr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== design/cnr_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle, with remainder.
`timescale 1ns / 1ps
module cnr_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cnr_pkg::D2_W-1:0]   radicand,
    output logic                       done,
    output logic [cnr_pkg::ROOT_W-1:0] root,
    output logic [cnr_pkg::ROOT_W:0]   rem
);
    import cnr_pkg::*;

    logic [2*SQ_STEPS-1:0] op_reg;
    logic [ROOT_W+2:0]     rem_reg, rem_next, rem_sh, trial;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [4:0]            cnt_reg;
    logic                  busy_reg, done_reg;

    always_comb
    begin
        rem_sh = {rem_reg[ROOT_W:0], op_reg[2*SQ_STEPS-1 -: 2]};
        trial = {1'b0, root_reg, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_next = rem_sh - trial;
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh;
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQ_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg <= (2*SQ_STEPS)'(radicand);
            rem_reg <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            op_reg <= {op_reg[2*SQ_STEPS-3:0], 2'b00};
            rem_reg <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;
    assign rem = rem_reg[ROOT_W:0];
endmodule

// ===== design/cnr_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module cnr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cnr_pkg::NUM_W-1:0]     num,
    input  logic [cnr_pkg::ROOT_W-1:0]    den,
    output logic                          done,
    output logic [cnr_pkg::DIV_STEPS-1:0] quot
);
    import cnr_pkg::*;

    logic [ROOT_W-1:0]    rem_reg, den_reg;
    logic [DIV_STEPS-1:0] lo_reg, q_reg;
    logic [ROOT_W:0]      sh, diff;
    logic                 bit_q;
    logic [4:0]           cnt_reg;
    logic                 busy_reg, done_reg;

    always_comb
    begin
        sh = {rem_reg, lo_reg[DIV_STEPS-1]};
        diff = sh - {1'b0, den_reg};
        bit_q = (sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= ROOT_W'(num[NUM_W-1:DIV_STEPS]);
            lo_reg <= num[DIV_STEPS-1:0];
            den_reg <= den;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= bit_q ? diff[ROOT_W-1:0] : sh[ROOT_W-1:0];
            lo_reg <= {lo_reg[DIV_STEPS-2:0], 1'b0};
            q_reg <= {q_reg[DIV_STEPS-2:0], bit_q};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

// ===== design/circle_nonpenetration_resolver.sv =====
// Top level: circle table, resolve sequencer and output word register.
// One word is in flight at a time; each word passes through the output state, which holds
// while the output is stalled, and then idle; the result word is registered as it leaves.
// Per slot a resolve runs read, check and next; a near slot adds multiply, the 26-step square
// root and overlap check, and a pushing slot two 26-step divisions and the update as well.
// Reset clears all eligible marks at once through per-slot valid flip-flops, no sweep.
`timescale 1ns / 1ps
module circle_nonpenetration_resolver (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot, pos_x, pos_y, radius, eligible, self_slot, self_in_table, zero fill
    input  logic [103:0] s_tdata,
    // operation
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_x, new_y, push_count, zero_distance, saturated, zero fill
    output logic [79:0]  m_tdata
);
    import cnr_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_RD   = 13'b0000000000010,
        ST_CHK  = 13'b0000000000100,
        ST_MUL  = 13'b0000000001000,
        ST_SQS  = 13'b0000000010000,
        ST_SQW  = 13'b0000000100000,
        ST_OVL  = 13'b0000001000000,
        ST_PM   = 13'b0000010000000,
        ST_DS   = 13'b0000100000000,
        ST_DW   = 13'b0001000000000,
        ST_UPD  = 13'b0010000000000,
        ST_NXT  = 13'b0100000000000,
        ST_OUT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0]         in_slot, in_self;
    logic signed [31:0] in_x, in_y;
    logic [23:0]        in_r;
    logic               in_elig, in_selfv;
    logic               accept;

    logic signed [31:0] cx_reg, cy_reg;
    logic [23:0]        rad_reg, er_reg;
    logic [5:0]         self_reg;
    logic               selfv_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [6:0]         cnt_reg;
    logic               zero_reg, sat_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [24:0]        magx_reg, magy_reg, ov_reg;
    logic               negx_reg, negy_reg, sel_y_reg;
    logic [49:0]        sqx_reg, sqy_reg, prod_reg;
    logic [ROOT_W-1:0]  dist_reg;
    logic [DIV_STEPS-1:0] qx_reg;
    logic               m_valid_reg;
    logic [79:0]        m_data_reg;

    logic               we;
    logic [IDX_W-1:0]   waddr;
    circle_t            wentry, rentry;
    logic [CIRCLE_W-1:0] rdata;

    logic signed [32:0] dx_w, dy_w;
    logic               far_w, skip_w;
    logic [24:0]        rsum_w;
    logic               sq_done, dv_done;
    logic [ROOT_W-1:0]  sq_root;
    logic [ROOT_W:0]    sq_rem;
    logic [DIV_STEPS-1:0] dv_q;
    logic [NUM_W-1:0]   dv_num;
    logic signed [33:0] px_w, py_w, nx_w, ny_w;
    logic signed [31:0] nxc_w, nyc_w;
    logic               satx_w, saty_w;
    logic               out_free;

    assign in_slot  = s_tdata[5:0];
    assign in_x     = s_tdata[37:6];
    assign in_y     = s_tdata[69:38];
    assign in_r     = s_tdata[93:70];
    assign in_elig  = s_tdata[94];
    assign in_self  = s_tdata[100:95];
    assign in_selfv = s_tdata[101];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign we = accept && !s_tuser && (int'(in_slot) < ENTRIES);
    assign waddr = IDX_W'(in_slot);
    assign wentry = '{elig: in_elig, r: in_r, y: in_y, x: in_x};

    cnr_ram #(.WIDTH(CIRCLE_W), .DEPTH(ENTRIES)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wentry),
        .re    (state_reg == ST_RD),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign rentry = rdata;

    always_comb
    begin
        dx_w = 33'(cx_reg) - 33'(rentry.x);
        dy_w = 33'(cy_reg) - 33'(rentry.y);
        far_w = (dx_w >= 33'sd33554432) || (dx_w <= -33'sd33554432)
             || (dy_w >= 33'sd33554432) || (dy_w <= -33'sd33554432);
        skip_w = !(valid_reg[idx_reg] && rentry.elig)
              || (selfv_reg && (int'(self_reg) == int'(idx_reg))) || far_w;
        rsum_w = 25'(rad_reg) + 25'(er_reg);
        dv_num = NUM_W'(prod_reg) + NUM_W'(dist_reg >> 1);
        px_w = negx_reg ? -34'(qx_reg) : 34'(qx_reg);
        py_w = negy_reg ? -34'(dv_q) : 34'(dv_q);
        nx_w = 34'(cx_reg) + px_w;
        ny_w = 34'(cy_reg) + py_w;
        satx_w = (nx_w > 34'sd2147483647) || (nx_w < -34'sd2147483648);
        saty_w = (ny_w > 34'sd2147483647) || (ny_w < -34'sd2147483648);
        nxc_w = (nx_w > 34'sd2147483647) ? 32'sh7FFFFFFF :
                (nx_w < -34'sd2147483648) ? 32'sh80000000 : nx_w[31:0];
        nyc_w = (ny_w > 34'sd2147483647) ? 32'sh7FFFFFFF :
                (ny_w < -34'sd2147483648) ? 32'sh80000000 : ny_w[31:0];
    end

    cnr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_SQS),
        .radicand (D2_W'(sqx_reg) + D2_W'(sqy_reg)),
        .done     (sq_done),
        .root     (sq_root),
        .rem      (sq_rem)
    );

    cnr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_DS),
        .num   (dv_num),
        .den   (dist_reg),
        .done  (dv_done),
        .quot  (dv_q)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = s_tuser ? ST_RD : ST_OUT;
            ST_RD:   state_next = ST_CHK;
            ST_CHK:  state_next = skip_w ? ST_NXT : ST_MUL;
            ST_MUL:  state_next = ST_SQS;
            ST_SQS:  state_next = ST_SQW;
            ST_SQW:  if (sq_done) state_next = ST_OVL;
            ST_OVL:
            begin
                if (({1'b0, rsum_w} <= dist_reg) || (magx_reg == '0 && magy_reg == '0))
                begin
                    state_next = ST_NXT;
                end
                else
                begin
                    state_next = ST_PM;
                end
            end
            ST_PM:   state_next = ST_DS;
            ST_DS:   state_next = ST_DW;
            ST_DW:   if (dv_done) state_next = sel_y_reg ? ST_UPD : ST_PM;
            ST_UPD:  state_next = ST_NXT;
            ST_NXT:  state_next = (idx_reg == IDX_W'(ENTRIES - 1)) ? ST_OUT : ST_RD;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            m_valid_reg <= 1'b0;
            idx_reg <= '0;
            cnt_reg <= '0;
            zero_reg <= 1'b0;
            sat_reg <= 1'b0;
            sel_y_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (m_valid_reg && m_tready && (state_reg != ST_OUT))
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg <= '0;
                        cnt_reg <= '0;
                        zero_reg <= 1'b0;
                        sat_reg <= 1'b0;
                    end
                end
                ST_OVL:
                begin
                    if (({1'b0, rsum_w} > dist_reg) && magx_reg == '0 && magy_reg == '0)
                    begin
                        zero_reg <= 1'b1;
                    end
                    sel_y_reg <= 1'b0;
                end
                ST_DW:
                begin
                    if (dv_done)
                    begin
                        sel_y_reg <= 1'b1;
                    end
                end
                ST_UPD:
                begin
                    if (satx_w || saty_w)
                    begin
                        sat_reg <= 1'b1;
                    end
                    if (cnt_reg != 7'(CNT_MAX))
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                ST_NXT:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cx_reg <= in_x;
                    cy_reg <= in_y;
                    rad_reg <= in_r;
                    self_reg <= in_self;
                    selfv_reg <= in_selfv;
                end
            end
            ST_CHK:
            begin
                negx_reg <= dx_w[32];
                negy_reg <= dy_w[32];
                magx_reg <= dx_w[32] ? 25'(-dx_w) : 25'(dx_w);
                magy_reg <= dy_w[32] ? 25'(-dy_w) : 25'(dy_w);
                er_reg <= rentry.r;
            end
            ST_MUL:
            begin
                sqx_reg <= magx_reg * magx_reg;
                sqy_reg <= magy_reg * magy_reg;
            end
            ST_SQW:
            begin
                if (sq_done)
                begin
                    dist_reg <= sq_root + ROOT_W'(sq_rem > {1'b0, sq_root});
                end
            end
            ST_OVL:
            begin
                ov_reg <= rsum_w - 25'(dist_reg);
            end
            ST_PM:
            begin
                prod_reg <= (sel_y_reg ? magy_reg : magx_reg) * ov_reg;
            end
            ST_DW:
            begin
                if (dv_done && !sel_y_reg)
                begin
                    qx_reg <= dv_q;
                end
            end
            ST_UPD:
            begin
                cx_reg <= nxc_w;
                cy_reg <= nyc_w;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_data_reg <= {7'd0, sat_reg, zero_reg, cnt_reg, cy_reg, cx_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("Accepted word did not start processing.");

    a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> state_reg == ST_SQW)
        else $error("Square root finished outside its wait state.");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        dv_done |-> state_reg == ST_DW)
        else $error("Division finished outside its wait state.");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && m_valid_reg && !m_tready) |=> m_valid_reg && $stable(m_data_reg))
        else $error("Output word overwritten while stalled.");
endmodule
